>>> rtl/dcf_pkg.sv
// Shared types, constants and decode helpers for the DCF77 time code decoder.
`timescale 1ns / 1ps
`default_nettype none

package dcf_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned THRESH_W   = 10;
  localparam int unsigned GAP_W      = 16;
  localparam int unsigned TIMEOUT_W  = 16;
  localparam int unsigned FRAME_W    = 60;
  localparam int unsigned BITCNT_W   = 6;

  localparam logic [THRESH_W-1:0]  THRESH_RESET  = 10'd140;
  localparam logic [GAP_W-1:0]     GAP_RESET     = 16'd1200;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd3000;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_MAX   = 16'hFFFF;

  localparam logic [BITCNT_W-1:0] LAST_BIT_POS = 6'd59;
  localparam logic [5:0]          LAST_SECOND  = 6'd59;
  localparam logic [6:0]          LAST_MINUTE  = 7'd59;
  localparam logic [5:0]          LAST_HOUR    = 6'd23;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIT_THRESHOLD = 2'd0,
    REG_MINUTE_GAP    = 2'd1,
    REG_SYNC_TIMEOUT  = 2'd2
  } cfg_reg_t;

  // result word, level_echo in the lowest bits
  typedef struct packed {
    logic       frame_closed;
    logic       synced;
    logic [7:0] year;
    logic [4:0] month;
    logic [5:0] day;
    logic [2:0] weekday;
    logic [5:0] hour;
    logic [6:0] minute;
    logic [5:0] second;
    logic       level_echo;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);
  localparam int unsigned OUT_W    = ((RESULT_W + 7) / 8) * 8;

  // two BCD digits to binary, no range check
  function automatic logic [7:0] bcd_to_bin(input logic [7:0] code);
    logic [7:0] tens;
    tens = {4'd0, code[7:4]};
    return (tens << 3) + (tens << 1) + {4'd0, code[3:0]};
  endfunction

endpackage

`default_nettype wire

>>> rtl/dcf77_time_code_decoder.sv
// DCF77 time code decoder: pin sample stream in, decoded time word per sample out.
// The result word for an input word is registered and appears in the cycle after it is accepted.
// Throughput: one word per cycle; s_tready drops only while the result register
// is full and m_tready is low.
// Reset (rst, synchronous): all decode state, held time fields and the sync flag
// clear; the configuration registers return to 140 ms, 1200 ms and 3000 samples.
`timescale 1ns / 1ps
`default_nettype none

module dcf77_time_code_decoder #(
  parameter int unsigned TIME_WIDTH = 16,
  localparam int unsigned IN_W = ((TIME_WIDTH + 1 + 7) / 8) * 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [IN_W-1:0]                  s_tdata,    // pin_level, now_ms
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // level_echo, second, minute, hour, weekday, day, month, year, synced, frame_closed
  output logic [dcf_pkg::OUT_W-1:0]             m_tdata,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [dcf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [dcf_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import dcf_pkg::*;

  localparam int unsigned CW = (TIME_WIDTH > GAP_W) ? TIME_WIDTH : GAP_W;

  logic [THRESH_W-1:0]   bit_threshold_ms;
  logic [GAP_W-1:0]      minute_gap_ms;
  logic [TIMEOUT_W-1:0]  sync_timeout_samples;

  logic                  last_level,     last_level_next;
  logic [TIME_WIDTH-1:0] last_rise_ms,   last_rise_ms_next;
  logic [BITCNT_W-1:0]   bit_count,      bit_count_next;
  logic [FRAME_W-1:0]    bit_buffer,     bit_buffer_next;
  logic [TIMEOUT_W-1:0]  timeout_count,  timeout_count_next;
  logic [5:0]            seconds_held,   seconds_held_next;
  logic [6:0]            minute_held,    minute_held_next;
  logic [5:0]            hour_held,      hour_held_next;
  logic [2:0]            weekday_held,   weekday_held_next;
  logic [5:0]            day_held,       day_held_next;
  logic [4:0]            month_held,     month_held_next;
  logic [7:0]            year_held,      year_held_next;
  logic                  sync_flag,      sync_flag_next;
  logic                  closed;
  result_t               result;

  logic                  accept;
  logic                  level;
  logic [TIME_WIDTH-1:0] now;
  logic [TIME_WIDTH-1:0] elapsed;
  logic [CW-1:0]         elapsed_ext;
  logic                  rise, fall;
  logic                  date_good;
  logic [TIMEOUT_W-1:0]  timeout_mid;
  logic                  sync_mid;

  assign accept    = s_tvalid && s_tready;
  assign s_tready  = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    level       = s_tdata[0];
    now         = s_tdata[TIME_WIDTH:1];
    elapsed     = now - last_rise_ms;
    elapsed_ext = CW'(elapsed);
    rise        = level && !last_level;
    fall        = !level && last_level;
    closed      = rise && (elapsed_ext > CW'(minute_gap_ms));
    date_good   = 1'b0;

    last_level_next   = level;
    last_rise_ms_next = last_rise_ms;
    bit_count_next    = bit_count;
    bit_buffer_next   = bit_buffer;
    seconds_held_next = seconds_held;
    minute_held_next  = minute_held;
    hour_held_next    = hour_held;
    weekday_held_next = weekday_held;
    day_held_next     = day_held;
    month_held_next   = month_held;
    year_held_next    = year_held;

    if (rise) begin
      seconds_held_next = (seconds_held == LAST_SECOND) ? 6'd0 : seconds_held + 6'd1;
      last_rise_ms_next = now;
    end

    if (fall) begin
      if (elapsed_ext >= CW'(bit_threshold_ms)) begin
        bit_buffer_next[bit_count] = 1'b1;
      end
      if (bit_count == LAST_BIT_POS) begin
        bit_count_next  = '0;
        bit_buffer_next = '0;
      end else begin
        bit_count_next = bit_count + 6'd1;
      end
    end

    if (closed) begin
      if (bit_count == LAST_BIT_POS) begin
        // minute: good parity loads, bad parity advances the held time
        if ((^bit_buffer[27:21]) == bit_buffer[28]) begin
          minute_held_next = 7'(bcd_to_bin({1'b0, bit_buffer[27:21]}));
        end else if (minute_held >= LAST_MINUTE) begin
          minute_held_next = '0;
          hour_held_next   = (hour_held >= LAST_HOUR) ? 6'd0 : hour_held + 6'd1;
        end else begin
          minute_held_next = minute_held + 7'd1;
        end
        if ((^bit_buffer[34:29]) == bit_buffer[35]) begin
          hour_held_next = 6'(bcd_to_bin({2'b0, bit_buffer[34:29]}));
        end
        if ((^bit_buffer[57:36]) == bit_buffer[58]) begin
          date_good         = 1'b1;
          weekday_held_next = bit_buffer[44:42];
          day_held_next     = 6'(bcd_to_bin({2'b0, bit_buffer[41:36]}));
          month_held_next   = 5'(bcd_to_bin({3'b0, bit_buffer[49:45]}));
          year_held_next    = bcd_to_bin(bit_buffer[57:50]);
        end
      end
      seconds_held_next = '0;
      bit_count_next    = '0;
      bit_buffer_next   = '0;
    end

    timeout_mid    = date_good ? '0 : timeout_count;
    sync_mid       = date_good ? 1'b1 : sync_flag;
    sync_flag_next = (timeout_mid > sync_timeout_samples) ? 1'b0 : sync_mid;
    timeout_count_next = (timeout_mid == TIMEOUT_MAX) ? timeout_mid
                                                      : timeout_mid + 16'd1;
  end

  always_comb begin
    result.level_echo   = level;
    result.second       = seconds_held_next;
    result.minute       = minute_held_next;
    result.hour         = hour_held_next;
    result.weekday      = weekday_held_next;
    result.day          = day_held_next;
    result.month        = month_held_next;
    result.year         = year_held_next;
    result.synced       = sync_flag_next;
    result.frame_closed = closed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_threshold_ms     <= THRESH_RESET;
      minute_gap_ms        <= GAP_RESET;
      sync_timeout_samples <= TIMEOUT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BIT_THRESHOLD: bit_threshold_ms     <= cfg_data[THRESH_W-1:0];
        REG_MINUTE_GAP:    minute_gap_ms        <= cfg_data[GAP_W-1:0];
        REG_SYNC_TIMEOUT:  sync_timeout_samples <= cfg_data[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level    <= 1'b0;
      last_rise_ms  <= '0;
      bit_count     <= '0;
      bit_buffer    <= '0;
      timeout_count <= '0;
      seconds_held  <= '0;
      minute_held   <= '0;
      hour_held     <= '0;
      weekday_held  <= '0;
      day_held      <= '0;
      month_held    <= '0;
      year_held     <= '0;
      sync_flag     <= 1'b0;
    end else if (accept) begin
      last_level    <= last_level_next;
      last_rise_ms  <= last_rise_ms_next;
      bit_count     <= bit_count_next;
      bit_buffer    <= bit_buffer_next;
      timeout_count <= timeout_count_next;
      seconds_held  <= seconds_held_next;
      minute_held   <= minute_held_next;
      hour_held     <= hour_held_next;
      weekday_held  <= weekday_held_next;
      day_held      <= day_held_next;
      month_held    <= month_held_next;
      year_held     <= year_held_next;
      sync_flag     <= sync_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= OUT_W'(result);
    end
  end

endmodule

`default_nettype wire

>>> rtl/dcf_checker.sv
// Port-level assertions for the DCF77 time code decoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module dcf_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       s_tready,
  input wire logic                       m_tvalid,
  input wire logic                       m_tready,
  input wire logic [dcf_pkg::OUT_W-1:0]  m_tdata
);
  import dcf_pkg::*;

  result_t res;
  assign res = result_t'(m_tdata[RESULT_W-1:0]);

  // no word left over from before reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result word changed");

  a_no_block: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid || m_tready) |-> s_tready)
    else $error("input stalled while output is free");

  a_second_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> res.second <= LAST_SECOND)
    else $error("second out of range");

  // a frame closes only on a rising edge and restarts the second count
  a_close: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.frame_closed |-> res.level_echo && res.second == 6'd0)
    else $error("frame close without rising edge or second reset");

endmodule

bind dcf77_time_code_decoder dcf_checker u_dcf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

>>> test/tb_dcf77_time_code_decoder.sv
// Self-checking bench for the DCF77 decoder: directed probes, then whole minute frames.
`timescale 1ns / 1ps

module tb_dcf77_time_code_decoder;
  import dcf_pkg::*;

  localparam int IN_W = 24;

  typedef struct packed {
    logic        lvl;
    logic [15:0] stamp;
    logic        typed;
    result_t     word;
  } probe_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [IN_W-1:0] s_tdata;    // pin_level, now_ms
  logic m_tvalid;
  logic m_tready;
  // level_echo, second, minute, hour, weekday, day, month, year, synced, frame_closed
  logic [OUT_W-1:0] m_tdata;
  logic cfg_valid;
  logic cfg_ready;
  cfg_reg_t cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  dcf77_time_code_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // decoder state as the bench sees it
  logic [9:0]  bit_thr;
  logic [15:0] min_gap;
  logic [15:0] sync_limit;
  logic        pin_was;
  logic [15:0] rise_at;
  logic [5:0]  nbits;
  logic [59:0] frame_bits;
  logic [15:0] since_date;
  logic [5:0]  sec_q;
  logic [6:0]  min_q;
  logic [5:0]  hour_q;
  logic [2:0]  wday_q;
  logic [5:0]  day_q;
  logic [4:0]  mon_q;
  logic [7:0]  year_q;
  logic        sync_q;

  result_t due_words[$];
  int errors = 0;

  // sender side
  logic    gen_level = 1'b0;
  logic [15:0] gen_rise = 16'd0;
  int      burst_left = 0;
  logic    cur_typed = 1'b0;
  result_t cur_word = '0;
  logic    hold_req = 1'b0;

  function automatic logic [7:0] bcd_bin(input logic [7:0] c);
    return 8'(c[7:4]) * 8'd10 + 8'(c[3:0]);
  endfunction

  function automatic result_t quiet_word(input logic lvl, input logic [5:0] sec,
                                         input logic closed);
    return {closed, 1'b0, 8'd0, 5'd0, 6'd0, 3'd0, 6'd0, 7'd0, sec, lvl};
  endfunction

  task automatic decode_sample(input logic lvl, input logic [15:0] stamp,
                               output result_t r);
    logic [15:0] elapsed;
    logic closed;
    closed = 1'b0;
    if (lvl != pin_was) begin
      elapsed = stamp - rise_at;
      if (lvl) begin
        sec_q = (sec_q >= 6'd59) ? 6'd0 : sec_q + 6'd1;
        if (elapsed > min_gap) begin
          closed = 1'b1;
          if (nbits == 6'd59) begin
            if (^frame_bits[27:21] == frame_bits[28]) begin
              min_q = 7'(bcd_bin({1'b0, frame_bits[27:21]}));
            end else if (min_q >= 7'd59) begin
              min_q = 7'd0;
              hour_q = (hour_q >= 6'd23) ? 6'd0 : hour_q + 6'd1;
            end else begin
              min_q = min_q + 7'd1;
            end
            if (^frame_bits[34:29] == frame_bits[35]) begin
              hour_q = 6'(bcd_bin({2'b0, frame_bits[34:29]}));
            end
            if (^frame_bits[57:36] == frame_bits[58]) begin
              wday_q = 3'(bcd_bin({5'b0, frame_bits[44:42]}));
              day_q = 6'(bcd_bin({2'b0, frame_bits[41:36]}));
              mon_q = 5'(bcd_bin({3'b0, frame_bits[49:45]}));
              year_q = bcd_bin(frame_bits[57:50]);
              since_date = 16'd0;
              sync_q = 1'b1;
            end
          end
          sec_q = 6'd0;
          nbits = 6'd0;
          frame_bits = '0;
        end
        rise_at = stamp;
      end else begin
        if (elapsed >= 16'(bit_thr)) begin
          frame_bits[nbits] = 1'b1;
        end
        nbits = (nbits >= 6'd59) ? 6'd0 : nbits + 6'd1;
        if (nbits == 6'd0) begin
          frame_bits = '0;
        end
      end
      pin_was = lvl;
    end
    if (since_date > sync_limit) begin
      sync_q = 1'b0;
    end
    if (since_date != 16'hFFFF) begin
      since_date = since_date + 16'd1;
    end
    r = {closed, sync_q, year_q, mon_q, day_q, wday_q, hour_q, min_q, sec_q, lvl};
  endtask

  always @(posedge clk) begin : sample_accept
    result_t r;
    if (!rst && s_tvalid && s_tready) begin
      decode_sample(s_tdata[0], s_tdata[16:1], r);
      due_words.push_back(cur_typed ? cur_word : r);
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[RESULT_W-1:0];
      if (due_words.size() == 0) begin
        errors++;
        $display("%0t: result word expected none actual %h", $time, got);
      end else begin
        want = due_words.pop_front();
        check_field("level_echo", want.level_echo, got.level_echo);
        check_field("second", want.second, got.second);
        check_field("minute", want.minute, got.minute);
        check_field("hour", want.hour, got.hour);
        check_field("weekday", want.weekday, got.weekday);
        check_field("day", want.day, got.day);
        check_field("month", want.month, got.month);
        check_field("year", want.year, got.year);
        check_field("synced", want.synced, got.synced);
        check_field("frame_closed", want.frame_closed, got.frame_closed);
      end
    end
  end

  // receiver: random stall masks, open stretches, and one long hold-off on request
  initial begin : receiver
    int step;
    int hold;
    logic [15:0] mask;
    step = 0;
    hold = 0;
    mask = '1;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold = 300;
        hold_req = 1'b0;
      end
      if (hold != 0) begin
        m_tready <= 1'b0;
        hold--;
      end else begin
        if (step % 64 == 0) begin
          mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h1111);
        end
        m_tready <= mask[step % 16];
        step++;
      end
    end
  end

  function automatic int pick(input int lo, input int hi);
    case ($urandom_range(0, 7))
      0: return lo;
      1: return hi;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  task automatic send_word(input logic lvl, input logic [15:0] stamp, input logic typed,
                           input result_t word);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        repeat ($urandom_range(1, 6)) begin
          @(negedge clk);
          s_tvalid <= 1'b0;
        end
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, stamp, lvl};
    cur_typed = typed;
    cur_word = word;
    if (lvl && !gen_level) begin
      gen_rise = stamp;
    end
    gen_level = lvl;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_noise(input int n);
    repeat (n) send_word(1'($urandom_range(0, 1)), 16'($urandom), 1'b0, '0);
  endtask

  // one second mark: rising edge, then falling edge whose pulse length sets the bit
  task automatic send_pulse(input logic closing, input logic one);
    logic [15:0] t;
    if (gen_level) begin
      send_word(1'b0, 16'($urandom), 1'b0, '0);
    end
    if (!closing) begin
      t = gen_rise + 16'(pick(1, int'(min_gap)));
    end else if (min_gap == 16'hFFFF) begin
      t = 16'($urandom);
    end else begin
      t = gen_rise + 16'(pick(int'(min_gap) + 1, 65535));
    end
    send_word(1'b1, t, 1'b0, '0);
    if ($urandom_range(0, 7) == 0) begin
      send_word(1'b1, 16'($urandom), 1'b0, '0);
    end
    if (one) begin
      send_word(1'b0, t + 16'(pick(int'(bit_thr), int'(bit_thr) + 300)), 1'b0, '0);
    end else begin
      send_word(1'b0, t + 16'(pick(0, int'(bit_thr) - 1)), 1'b0, '0);
    end
    if ($urandom_range(0, 7) == 0) begin
      send_word(1'b0, 16'($urandom), 1'b0, '0);
    end
  endtask

  task automatic send_frame(input int count, input logic [59:0] f);
    for (int k = 0; k < count; k++) begin
      send_pulse(k == 0, f[k]);
    end
  endtask

  function automatic logic [59:0] make_frame(input logic at_2359, input logic bad_min,
                                             input logic bad_hour, input logic bad_date);
    logic [59:0] f;
    f = {28'($urandom), 32'($urandom)};
    if (at_2359) begin
      f[27:21] = 7'h59;
      f[34:29] = 6'h23;
    end
    f[28] = ^f[27:21] ^ bad_min;
    f[35] = ^f[34:29] ^ bad_hour;
    f[58] = ^f[57:36] ^ bad_date;
    return f;
  endfunction

  function automatic logic [59:0] any_frame();
    return make_frame(1'b0, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
                      $urandom_range(0, 3) == 0);
  endfunction

  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_BIT_THRESHOLD: bit_thr = val[9:0];
      REG_MINUTE_GAP:    min_gap = val;
      default:           sync_limit = val;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input logic [9:0] thr, input logic [15:0] gap,
                            input logic [15:0] lim);
    wait_idle();
    cfg_write(REG_BIT_THRESHOLD, {6'($urandom), thr});
    cfg_write(REG_MINUTE_GAP, gap);
    cfg_write(REG_SYNC_TIMEOUT, lim);
  endtask

  initial begin : stimulus
    probe_t probes [16];
    logic [9:0] thr;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_BIT_THRESHOLD;
    cfg_data = '0;
    bit_thr = 10'd140;
    min_gap = 16'd1200;
    sync_limit = 16'd3000;
    pin_was = 1'b0;
    rise_at = '0;
    nbits = '0;
    frame_bits = '0;
    since_date = '0;
    sec_q = '0;
    min_q = '0;
    hour_q = '0;
    wday_q = '0;
    day_q = '0;
    mon_q = '0;
    year_q = '0;
    sync_q = 1'b0;

    // reset values: threshold 140, gap 1200
    probes[0]  = {1'b0, 16'h0000, 1'b1, quiet_word(1'b0, 6'd0, 1'b0)};
    probes[1]  = {1'b0, 16'hFFFF, 1'b1, quiet_word(1'b0, 6'd0, 1'b0)};
    probes[2]  = {1'b1, 16'h0000, 1'b1, quiet_word(1'b1, 6'd1, 1'b0)};
    probes[3]  = {1'b1, 16'h1234, 1'b1, quiet_word(1'b1, 6'd1, 1'b0)};
    probes[4]  = {1'b0, 16'd139,  1'b1, quiet_word(1'b0, 6'd1, 1'b0)};  // just below threshold
    probes[5]  = {1'b1, 16'd1200, 1'b1, quiet_word(1'b1, 6'd2, 1'b0)};  // gap equal, no close
    probes[6]  = {1'b0, 16'd1340, 1'b1, quiet_word(1'b0, 6'd2, 1'b0)};  // at threshold
    probes[7]  = {1'b1, 16'd2401, 1'b1, quiet_word(1'b1, 6'd0, 1'b1)};  // short frame closes
    probes[8]  = {1'b0, 16'd2401, 1'b1, quiet_word(1'b0, 6'd0, 1'b0)};
    probes[9]  = {1'b1, 16'h0010, 1'b1, quiet_word(1'b1, 6'd0, 1'b1)};  // gap across wrap
    probes[10] = {1'b0, 16'hFFF0, 1'b1, quiet_word(1'b0, 6'd0, 1'b0)};
    probes[11] = {1'b1, 16'h0400, 1'b1, quiet_word(1'b1, 6'd1, 1'b0)};
    probes[12] = {1'b1, 16'h0400, 1'b0, result_t'('0)};
    probes[13] = {1'b0, 16'h07FF, 1'b0, result_t'('0)};
    probes[14] = {1'b1, 16'h7FFF, 1'b0, result_t'('0)};
    probes[15] = {1'b0, 16'h8000, 1'b0, result_t'('0)};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (probes[i]) begin
      send_word(probes[i].lvl, probes[i].stamp, probes[i].typed, probes[i].word);
    end

    // default timing, 23:59 then bad minute and hour parity to force both wraps
    set_config(10'd140, 16'd1200, 16'd3000);
    send_frame(59, make_frame(1'b1, 1'b0, 1'b0, 1'b0));
    hold_req = 1'b1;
    send_frame(59, make_frame(1'b0, 1'b1, 1'b1, 1'b0));
    send_pulse(1'b1, 1'b0);
    send_noise(10);

    // no frame can close; 60 bits overflow the buffer; sync drops at once
    set_config(10'd1023, 16'hFFFF, 16'd0);
    send_noise(10);
    send_frame(60, any_frame());

    thr = 10'($urandom_range(2, 1023));
    set_config(thr, 16'($urandom_range(int'(thr), 20000)), 16'($urandom_range(20, 150)));
    send_noise(20);

    wait_idle();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
